// File: design/twcq_pkg.sv
// Shared types, codes and default sizes for the timed wheel command queue.
// No dependencies; used by twcq_ctrl, twcq_dpath and the top level.

package twcq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TIME_BITS   = 32;
    localparam int IN_TIME_W       = 32;   // width of time fields on the bus
    localparam int SPEED_W         = 16;
    localparam int CFG_W           = 32;   // widest register
    localparam int CFG_IDX_W       = 2;
    localparam int STATUS_W        = 3;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_TICK = 2'd1,
        CMD_STOP = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_PAST      = 3'd1,
        STAT_NOT_AFTER = 3'd2,
        STAT_BELOW_MIN = 3'd3,
        STAT_MEAN_HIGH = 3'd4,
        STAT_TOO_SOON  = 3'd5,
        STAT_STEP_BIG  = 3'd6,
        STAT_FULL      = 3'd7
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_REVERSE  = 2'd0,
        CFG_MAX_MEAN     = 2'd1,
        CFG_MIN_INTERVAL = 2'd2,
        CFG_MAX_STEP     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EXEC = 2'd2
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic exec;      // evaluate, commit state, load result
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_blocked;   // result register full and not being taken
    } dp_status_t;

endpackage

// File: design/twcq_ctrl.sv
// Sequencer for the command queue: accept, memory read, execute.
// Depends on twcq_pkg; drives twcq_dpath through ctrl_cmd_t.

module twcq_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  twcq_pkg::dp_status_t   stat,
    output twcq_pkg::ctrl_cmd_t    cmd
);

    twcq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= twcq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            twcq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = twcq_pkg::ST_READ;
                end
            end
            twcq_pkg::ST_READ: begin
                state_next = twcq_pkg::ST_EXEC;
            end
            twcq_pkg::ST_EXEC: begin
                // hold until the result register can take a new word
                if (!stat.out_blocked) begin
                    cmd.exec   = 1'b1;
                    state_next = twcq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = twcq_pkg::ST_IDLE;
            end
        endcase
    end

    a_capture_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg == twcq_pkg::ST_READ)
        else $error("capture not followed by read cycle");

    a_read_execs: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == twcq_pkg::ST_READ |=> state_reg == twcq_pkg::ST_EXEC)
        else $error("read cycle not followed by execute");

    a_exec_unblocked: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> !stat.out_blocked)
        else $error("execute while result register blocked");

endmodule

// File: design/twcq_dpath.sv
// Datapath: config registers, command memory, pointers, checks and result register.
// Depends on twcq_pkg; sequenced by twcq_ctrl.

module twcq_dpath #(
    parameter int QUEUE_DEPTH = twcq_pkg::DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = twcq_pkg::DEF_TIME_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [twcq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [twcq_pkg::CFG_W-1:0]           cfg_wdata,
    input  twcq_pkg::ctrl_cmd_t                  cmd,
    output twcq_pkg::dp_status_t                 stat,
    input  logic [1:0]                           in_cmd,
    input  logic [twcq_pkg::IN_TIME_W-1:0]       in_now,
    input  logic [twcq_pkg::IN_TIME_W-1:0]       in_action,
    input  logic signed [twcq_pkg::SPEED_W-1:0]  in_left,
    input  logic signed [twcq_pkg::SPEED_W-1:0]  in_right,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [twcq_pkg::STATUS_W-1:0]        out_status,
    output logic                                 out_applied,
    output logic signed [twcq_pkg::SPEED_W-1:0]  out_left,
    output logic signed [twcq_pkg::SPEED_W-1:0]  out_right,
    output logic                                 out_halted,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     out_level
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = TIME_BITS;
    localparam int SW = twcq_pkg::SPEED_W;

    typedef struct packed {
        logic [TW-1:0]        t;
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
    } entry_t;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
        if (p == PW'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // configuration
    logic [14:0]   min_rev_reg;
    logic [14:0]   max_mean_reg;
    logic [TW-1:0] min_int_reg;
    logic [15:0]   max_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_rev_reg  <= '0;
            max_mean_reg <= 15'h7fff;
            min_int_reg  <= '0;
            max_step_reg <= 16'hffff;
        end else if (cfg_wr_en) begin
            case (twcq_pkg::cfg_idx_t'(cfg_index))
                twcq_pkg::CFG_MIN_REVERSE:  min_rev_reg  <= cfg_wdata[14:0];
                twcq_pkg::CFG_MAX_MEAN:     max_mean_reg <= cfg_wdata[14:0];
                twcq_pkg::CFG_MIN_INTERVAL: min_int_reg  <= TW'(cfg_wdata);
                twcq_pkg::CFG_MAX_STEP:     max_step_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // captured word
    twcq_pkg::cmd_t       cmd_q;
    logic [TW-1:0]        now_q, act_q;
    logic signed [SW-1:0] left_q, right_q;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_q   <= twcq_pkg::cmd_t'(in_cmd);
            now_q   <= TW'(in_now);
            act_q   <= TW'(in_action);
            left_q  <= in_left;
            right_q <= in_right;
        end
    end

    // queue state
    logic [PW-1:0]        head_reg, head_next, tail_reg, tail_next;
    logic [LW-1:0]        fill_reg, fill_next;
    logic signed [SW-1:0] lspd_reg, lspd_next, rspd_reg, rspd_next;
    logic                 halted_reg, halted_next;
    logic                 outv_reg, outv_next;

    logic [PW-1:0] last_idx;
    assign last_idx = (tail_reg == '0) ? PW'(QUEUE_DEPTH - 1) : tail_reg - 1'b1;

    // command memory: one write, two registered reads (head and last entry)
    entry_t mem [QUEUE_DEPTH];
    entry_t head_rd_reg, last_rd_reg;
    logic   wr_en;
    entry_t wr_entry;

    assign wr_entry.t = act_q;
    assign wr_entry.l = left_q;
    assign wr_entry.r = right_q;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= wr_entry;
        end
        head_rd_reg <= mem[head_reg];
        last_rd_reg <= mem[last_idx];
    end

    // push checks
    logic                 have_last;
    logic signed [17:0]   l18, r18, vmin18, sum18, mean_lim18;
    logic signed [16:0]   dl17, dr17;
    logic [16:0]          absl, absr;
    logic [TW-1:0]        gap;
    logic                 below_min, mean_high, too_soon, step_big, full, tick_ok;
    twcq_pkg::status_t    push_status;

    always_comb begin
        have_last  = fill_reg != '0;
        l18        = {{2{left_q[SW-1]}}, left_q};
        r18        = {{2{right_q[SW-1]}}, right_q};
        vmin18     = {3'b000, min_rev_reg};
        below_min  = ((l18 + vmin18) <= 18'sd0) || ((r18 + vmin18) <= 18'sd0);
        sum18      = l18 + r18;
        mean_lim18 = {2'b00, max_mean_reg, 1'b0};
        mean_high  = sum18 >= mean_lim18;
        gap        = act_q - last_rd_reg.t;
        too_soon   = gap < min_int_reg;
        dl17       = {left_q[SW-1], left_q} - {last_rd_reg.l[SW-1], last_rd_reg.l};
        dr17       = {right_q[SW-1], right_q} - {last_rd_reg.r[SW-1], last_rd_reg.r};
        absl       = dl17[16] ? 17'(-dl17) : 17'(dl17);
        absr       = dr17[16] ? 17'(-dr17) : 17'(dr17);
        step_big   = (absl >= {1'b0, max_step_reg}) || (absr >= {1'b0, max_step_reg});
        full       = fill_reg >= LW'(QUEUE_DEPTH);
        tick_ok    = have_last && (now_q >= head_rd_reg.t);

        if (act_q < now_q) begin
            push_status = twcq_pkg::STAT_PAST;
        end else if (have_last && act_q <= last_rd_reg.t) begin
            push_status = twcq_pkg::STAT_NOT_AFTER;
        end else if (below_min) begin
            push_status = twcq_pkg::STAT_BELOW_MIN;
        end else if (mean_high) begin
            push_status = twcq_pkg::STAT_MEAN_HIGH;
        end else if (have_last && too_soon) begin
            push_status = twcq_pkg::STAT_TOO_SOON;
        end else if (have_last && step_big) begin
            push_status = twcq_pkg::STAT_STEP_BIG;
        end else if (full) begin
            push_status = twcq_pkg::STAT_FULL;
        end else begin
            push_status = twcq_pkg::STAT_OK;
        end
    end

    // commit
    twcq_pkg::status_t res_status;
    logic              res_applied;

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        lspd_next   = lspd_reg;
        rspd_next   = rspd_reg;
        halted_next = halted_reg;
        wr_en       = 1'b0;
        res_status  = twcq_pkg::STAT_OK;
        res_applied = 1'b0;
        if (cmd.exec) begin
            case (cmd_q)
                twcq_pkg::CMD_PUSH: begin
                    res_status = push_status;
                    if (push_status == twcq_pkg::STAT_OK) begin
                        wr_en     = 1'b1;
                        tail_next = adv(tail_reg);
                        fill_next = fill_reg + 1'b1;
                    end
                end
                twcq_pkg::CMD_TICK: begin
                    if (tick_ok) begin
                        lspd_next   = head_rd_reg.l;
                        rspd_next   = head_rd_reg.r;
                        head_next   = adv(head_reg);
                        fill_next   = fill_reg - 1'b1;
                        res_applied = 1'b1;
                    end
                end
                twcq_pkg::CMD_STOP: begin
                    lspd_next   = '0;
                    rspd_next   = '0;
                    head_next   = '0;
                    tail_next   = '0;
                    fill_next   = '0;
                    halted_next = 1'b1;
                end
                default: ;
            endcase
        end
        outv_next = cmd.exec ? 1'b1 : (outv_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            lspd_reg   <= '0;
            rspd_reg   <= '0;
            halted_reg <= 1'b0;
            outv_reg   <= 1'b0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            lspd_reg   <= lspd_next;
            rspd_reg   <= rspd_next;
            halted_reg <= halted_next;
            outv_reg   <= outv_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_status  <= res_status;
            out_applied <= res_applied;
            out_left    <= lspd_next;
            out_right   <= rspd_next;
            out_halted  <= halted_next;
            out_level   <= fill_next;
        end
    end

    assign out_valid        = outv_reg;
    assign stat.out_blocked = outv_reg && !out_ready;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LW'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared without reset");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && cmd_q == twcq_pkg::CMD_PUSH && push_status == twcq_pkg::STAT_OK)
        |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("accepted push did not grow the queue");

endmodule

// File: design/timed_wheel_command_queue.sv
// Top level of the timed wheel command queue: ports, word packing, sequencer and datapath.
// Depends on twcq_pkg, twcq_ctrl and twcq_dpath.
//
//  channel   dir  payload                                            handshake
//  s_axis    in   tdata: now_time, action_time, left, right; tuser: cmd   tvalid/tready
//  m_axis    out  tdata: status, applied, left_now, right_now,        tvalid/tready
//                 halted, queue_level
//  cfg       in   cfg_index, cfg_wdata                                cfg_wr_en, no wait
//
//  Each word passes through accept, queue memory read (registered read of the head
//  and last entries), then check and commit. The single result register lets the next
//  word be accepted while a result waits; execution of that word holds while the
//  result register is still full. Reset (aresetn low, synchronous) empties the queue,
//  clears speeds and the halted flag and loads register defaults; no memory sweep.

module timed_wheel_command_queue #(
    parameter int QUEUE_DEPTH = twcq_pkg::DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = twcq_pkg::DEF_TIME_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [31:0] now_time, [63:32] action_time, [79:64] left_request, [95:80] right_request
    input  logic [95:0]                           s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]                            s_axis_tuser,
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [2:0] status, [3] applied, [19:4] left_now, [35:20] right_now, [36] halted,
    // then queue_level, zero padded to whole bytes
    output logic [((37 + $clog2(QUEUE_DEPTH+1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [twcq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [twcq_pkg::CFG_W-1:0]            cfg_wdata
);

    localparam int LW          = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W       = 37 + LW;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int SW          = twcq_pkg::SPEED_W;
    localparam int IW          = twcq_pkg::IN_TIME_W;

    twcq_pkg::ctrl_cmd_t  cmd;
    twcq_pkg::dp_status_t stat;

    logic [twcq_pkg::STATUS_W-1:0] res_status;
    logic                          res_applied;
    logic signed [SW-1:0]          res_left, res_right;
    logic                          res_halted;
    logic [LW-1:0]                 res_level;

    twcq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    twcq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .stat        (stat),
        .in_cmd      (s_axis_tuser),
        .in_now      (s_axis_tdata[IW-1:0]),
        .in_action   (s_axis_tdata[2*IW-1:IW]),
        .in_left     (s_axis_tdata[2*IW+SW-1:2*IW]),
        .in_right    (s_axis_tdata[2*IW+2*SW-1:2*IW+SW]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (res_status),
        .out_applied (res_applied),
        .out_left    (res_left),
        .out_right   (res_right),
        .out_halted  (res_halted),
        .out_level   (res_level)
    );

    // pack the result word, lowest field first
    assign m_axis_tdata = OUT_TDATA_W'({res_level, res_halted, res_right, res_left,
                                        res_applied, res_status});

endmodule
